// ===== src/single_qubit_gate_apply_macros.svh =====
// ----------------------------------------------------------------------------
// single qubit gate apply assertion macros
// shared concurrent assertion forms, clocked on i_clk with active-low reset
// ----------------------------------------------------------------------------
`ifndef SINGLE_QUBIT_GATE_APPLY_MACROS_SVH
`define SINGLE_QUBIT_GATE_APPLY_MACROS_SVH

// consequent checked in the same cycle
`define SQG_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the next cycle
`define SQG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/sqg_pkg.sv =====
// ----------------------------------------------------------------------------
// sqg_pkg
// shared types, register map, status codes and controller states
// ----------------------------------------------------------------------------
package sqg_pkg;

    localparam int MAX_QUBITS_DEF = 10;
    localparam int AMP_W          = 16;
    localparam int QC_W           = 4;
    localparam int GATE_W         = 32;
    localparam int PADDR_W        = 5;
    localparam int PDATA_W        = 32;
    localparam int STATUS_W       = 2;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_INDEX  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_TARGET = 2'd2;

    localparam logic [2:0] REG_G00    = 3'd0;
    localparam logic [2:0] REG_G01    = 3'd1;
    localparam logic [2:0] REG_G10    = 3'd2;
    localparam logic [2:0] REG_G11    = 3'd3;
    localparam logic [2:0] REG_QCOUNT = 3'd4;
    localparam logic [2:0] REG_TARGET = 3'd5;

    localparam logic [GATE_W-1:0] GATE_ONE  = 32'h4000_0000;
    localparam logic [GATE_W-1:0] GATE_ZERO = 32'h0000_0000;
    localparam logic [QC_W-1:0]   QCOUNT_RST = 4'd10;
    localparam logic [QC_W-1:0]   TARGET_RST = 4'd1;

    typedef struct packed {
        logic [GATE_W-1:0] g00;
        logic [GATE_W-1:0] g01;
        logic [GATE_W-1:0] g10;
        logic [GATE_W-1:0] g11;
        logic [QC_W-1:0]   qubit_count;
        logic [QC_W-1:0]   target_qubit;
    } t_cfg;

    typedef struct packed {
        logic accept;
        logic prod0;
        logic prod1;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic is_read;
        logic item_err;
        logic out_free;
    } t_sts;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_FETCH = 4'b0010,
        S_PROD  = 4'b0100,
        S_OUT   = 4'b1000
    } t_state;

endpackage

// ===== src/single_qubit_gate_apply.sv =====
// ----------------------------------------------------------------------------
// single_qubit_gate_apply
// Holds a state vector of 2^MAX_QUBITS complex Q2.14 amplitudes in a
// single-port memory. A write transaction stores one amplitude. A read
// transaction applies the 2x2 gate on the target qubit and passes through the
// fetch, product and output steps to the result register: the two partner
// amplitudes come out of the one memory port on consecutive cycles, each goes
// through a shared complex multiplier, and the sum is rounded and saturated.
// No new item is taken until the controller is back in idle; a waiting result
// holds the controller in its last step until it is taken. Bad reads go
// straight to that step and return with status set and zero data. The memory
// is not cleared: read only amplitudes that were written.
// ----------------------------------------------------------------------------
module single_qubit_gate_apply #(
    parameter int MAX_QUBITS = sqg_pkg::MAX_QUBITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [sqg_pkg::PADDR_W-1:0]        paddr,
    input  logic [sqg_pkg::PDATA_W-1:0]        pwdata,
    output logic [sqg_pkg::PDATA_W-1:0]        prdata,
    output logic                               pready,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_func,
    input  logic [MAX_QUBITS-1:0]              i_amp_index,
    input  logic signed [sqg_pkg::AMP_W-1:0]   i_real_in,
    input  logic signed [sqg_pkg::AMP_W-1:0]   i_imag_in,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [MAX_QUBITS-1:0]              o_out_index,
    output logic signed [sqg_pkg::AMP_W-1:0]   o_real_out,
    output logic signed [sqg_pkg::AMP_W-1:0]   o_imag_out,
    output logic [sqg_pkg::STATUS_W-1:0]       o_status
);

    sqg_pkg::t_cfg cfg;
    sqg_pkg::t_cmd cmd;
    sqg_pkg::t_sts sts;

    sqg_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    sqg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    sqg_dp #(
        .MAX_QUBITS (MAX_QUBITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_func      (i_func),
        .i_amp_index (i_amp_index),
        .i_real_in   (i_real_in),
        .i_imag_in   (i_imag_in),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_index (o_out_index),
        .o_real_out  (o_real_out),
        .o_imag_out  (o_imag_out),
        .o_status    (o_status)
    );

endmodule

// ===== src/sqg_ram.sv =====
// ----------------------------------------------------------------------------
// sqg_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module sqg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/sqg_regs.sv =====
// ----------------------------------------------------------------------------
// sqg_regs
// apb register file holding the gate matrix, qubit count and target qubit
// ----------------------------------------------------------------------------
module sqg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sqg_pkg::PADDR_W-1:0]   paddr,
    input  logic [sqg_pkg::PDATA_W-1:0]   pwdata,
    output logic [sqg_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output sqg_pkg::t_cfg                 o_cfg
);

    sqg_pkg::t_cfg r_cfg;
    logic          wr_en;
    logic [2:0]    reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = paddr[sqg_pkg::PADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.g00          <= sqg_pkg::GATE_ONE;
            r_cfg.g01          <= sqg_pkg::GATE_ZERO;
            r_cfg.g10          <= sqg_pkg::GATE_ZERO;
            r_cfg.g11          <= sqg_pkg::GATE_ONE;
            r_cfg.qubit_count  <= sqg_pkg::QCOUNT_RST;
            r_cfg.target_qubit <= sqg_pkg::TARGET_RST;
        end else if (wr_en) begin
            case (reg_sel)
                sqg_pkg::REG_G00:    r_cfg.g00          <= pwdata;
                sqg_pkg::REG_G01:    r_cfg.g01          <= pwdata;
                sqg_pkg::REG_G10:    r_cfg.g10          <= pwdata;
                sqg_pkg::REG_G11:    r_cfg.g11          <= pwdata;
                sqg_pkg::REG_QCOUNT: r_cfg.qubit_count  <= pwdata[sqg_pkg::QC_W-1:0];
                sqg_pkg::REG_TARGET: r_cfg.target_qubit <= pwdata[sqg_pkg::QC_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            sqg_pkg::REG_G00:    prdata = r_cfg.g00;
            sqg_pkg::REG_G01:    prdata = r_cfg.g01;
            sqg_pkg::REG_G10:    prdata = r_cfg.g10;
            sqg_pkg::REG_G11:    prdata = r_cfg.g11;
            sqg_pkg::REG_QCOUNT: prdata = sqg_pkg::PDATA_W'(r_cfg.qubit_count);
            sqg_pkg::REG_TARGET: prdata = sqg_pkg::PDATA_W'(r_cfg.target_qubit);
            default:             prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== src/sqg_ctrl.sv =====
// ----------------------------------------------------------------------------
// sqg_ctrl
// controller sequencing acceptance, the two amplitude fetches and the result
// ----------------------------------------------------------------------------
`include "single_qubit_gate_apply_macros.svh"

module sqg_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  sqg_pkg::t_sts i_sts,
    output sqg_pkg::t_cmd o_cmd
);

    sqg_pkg::t_state r_state;
    sqg_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sqg_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            sqg_pkg::S_IDLE: begin
                o_cmd.accept = i_in_valid;
                if (i_in_valid && i_sts.is_read) begin
                    n_state = i_sts.item_err ? sqg_pkg::S_OUT : sqg_pkg::S_FETCH;
                end
            end
            sqg_pkg::S_FETCH: begin
                o_cmd.prod0 = 1'b1;
                n_state     = sqg_pkg::S_PROD;
            end
            sqg_pkg::S_PROD: begin
                o_cmd.prod1 = 1'b1;
                n_state     = sqg_pkg::S_OUT;
            end
            sqg_pkg::S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = sqg_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sqg_pkg::S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != sqg_pkg::S_IDLE);

    `SQG_ASSERT_NEXT(a_good_read_fetches, r_state == sqg_pkg::S_IDLE && i_in_valid && i_sts.is_read && !i_sts.item_err, r_state == sqg_pkg::S_FETCH, "valid read did not start a fetch")
    `SQG_ASSERT_NEXT(a_write_stays_idle, r_state == sqg_pkg::S_IDLE && i_in_valid && !i_sts.is_read, r_state == sqg_pkg::S_IDLE, "write left the idle state")
    `SQG_ASSERT_NEXT(a_fetch_then_prod, r_state == sqg_pkg::S_FETCH, r_state == sqg_pkg::S_PROD && $past(o_cmd.prod0), "second fetch skipped")
    `SQG_ASSERT_NEXT(a_result_waits, r_state == sqg_pkg::S_OUT && !i_sts.out_free, r_state == sqg_pkg::S_OUT, "result dropped while output busy")

endmodule

// ===== src/sqg_dp.sv =====
// ----------------------------------------------------------------------------
// sqg_dp
// datapath: index checks, partner addressing, amplitude memory, shared
// complex multiplier, sum with rounding and saturation, output register
// ----------------------------------------------------------------------------
module sqg_dp #(
    parameter int MAX_QUBITS = sqg_pkg::MAX_QUBITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  sqg_pkg::t_cfg                        i_cfg,
    input  sqg_pkg::t_cmd                        i_cmd,
    output sqg_pkg::t_sts                        o_sts,
    input  logic                                 i_func,
    input  logic [MAX_QUBITS-1:0]                i_amp_index,
    input  logic signed [sqg_pkg::AMP_W-1:0]     i_real_in,
    input  logic signed [sqg_pkg::AMP_W-1:0]     i_imag_in,
    input  logic                                 i_out_stall,
    output logic                                 o_out_valid,
    output logic [MAX_QUBITS-1:0]                o_out_index,
    output logic signed [sqg_pkg::AMP_W-1:0]     o_real_out,
    output logic signed [sqg_pkg::AMP_W-1:0]     o_imag_out,
    output logic [sqg_pkg::STATUS_W-1:0]         o_status
);

    localparam int AW    = sqg_pkg::AMP_W;
    localparam int DEPTH = 1 << MAX_QUBITS;
    localparam int NW    = $clog2(MAX_QUBITS + 1);
    localparam int CW    = (NW > sqg_pkg::QC_W) ? NW : sqg_pkg::QC_W;
    localparam int PW    = 2 * AW;
    localparam int SW    = PW + 3;
    localparam int QW    = SW - 14;
    localparam logic signed [QW-1:0] Q_MAX = QW'(32767);
    localparam logic signed [QW-1:0] Q_MIN = -QW'(32768);

    // index and target checks
    logic [CW-1:0]          qc_ext;
    logic [CW-1:0]          tq_ext;
    logic [CW-1:0]          n_eff;
    logic [CW-1:0]          pos;
    logic [MAX_QUBITS-1:0]  size_mask;
    logic [MAX_QUBITS-1:0]  part_mask;
    logic                   idx_ok;
    logic                   tgt_ok;
    logic [sqg_pkg::STATUS_W-1:0] item_status;
    logic [MAX_QUBITS-1:0]  idx0;
    logic [MAX_QUBITS-1:0]  idx1;

    assign qc_ext = CW'(i_cfg.qubit_count);
    assign tq_ext = CW'(i_cfg.target_qubit);
    assign n_eff  = (qc_ext > CW'(MAX_QUBITS)) ? CW'(MAX_QUBITS) : qc_ext;
    assign pos    = n_eff - tq_ext;

    always_comb begin
        for (int b = 0; b < MAX_QUBITS; b++) begin
            size_mask[b] = (CW'(b) < n_eff);
            part_mask[b] = (pos == CW'(b));
        end
    end

    assign idx_ok = ~|(i_amp_index & ~size_mask);
    assign tgt_ok = (tq_ext != '0) && (tq_ext <= n_eff);
    assign idx0   = i_amp_index & ~part_mask;
    assign idx1   = i_amp_index | part_mask;

    always_comb begin
        if (!idx_ok) begin
            item_status = sqg_pkg::STATUS_BAD_INDEX;
        end else if (!tgt_ok) begin
            item_status = sqg_pkg::STATUS_BAD_TARGET;
        end else begin
            item_status = sqg_pkg::STATUS_OK;
        end
    end

    // latched read item
    logic [MAX_QUBITS-1:0]        r_idx;
    logic [MAX_QUBITS-1:0]        r_i1;
    logic                         r_row;
    logic [sqg_pkg::STATUS_W-1:0] r_status;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_idx    <= i_amp_index;
            r_i1     <= idx1;
            r_row    <= |(i_amp_index & part_mask);
            r_status <= item_status;
        end
    end

    // amplitude memory, first partner addressed straight from the input
    logic                  ram_we;
    logic [MAX_QUBITS-1:0] ram_addr;
    logic [PW-1:0]         ram_rdata;

    assign ram_we   = i_cmd.accept && (i_func == sqg_pkg::FUNC_WRITE) && idx_ok;
    assign ram_addr = !i_cmd.accept ? r_i1 :
                      (i_func == sqg_pkg::FUNC_READ) ? idx0 : i_amp_index;

    sqg_ram #(
        .WIDTH (PW),
        .DEPTH (DEPTH)
    ) u_amp_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata ({i_real_in, i_imag_in}),
        .o_rdata (ram_rdata)
    );

    // shared complex multiplier, column 0 then column 1
    logic [sqg_pkg::GATE_W-1:0] g_sel;
    logic signed [AW-1:0]       ar, ai, gr, gi;
    logic signed [PW-1:0]       r_prr, r_pii, r_pri, r_pir;
    logic signed [PW:0]         r_s0_re, r_s0_im;

    always_comb begin
        if (r_row) begin
            g_sel = i_cmd.prod1 ? i_cfg.g11 : i_cfg.g10;
        end else begin
            g_sel = i_cmd.prod1 ? i_cfg.g01 : i_cfg.g00;
        end
    end

    assign ar = $signed(ram_rdata[PW-1:AW]);
    assign ai = $signed(ram_rdata[AW-1:0]);
    assign gr = $signed(g_sel[sqg_pkg::GATE_W-1:AW]);
    assign gi = $signed(g_sel[AW-1:0]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.prod0 || i_cmd.prod1) begin
            r_prr <= PW'(gr) * PW'(ar);
            r_pii <= PW'(gi) * PW'(ai);
            r_pri <= PW'(gr) * PW'(ai);
            r_pir <= PW'(gi) * PW'(ar);
        end
        if (i_cmd.prod1) begin
            r_s0_re <= (PW + 1)'(r_prr) - (PW + 1)'(r_pii);
            r_s0_im <= (PW + 1)'(r_pri) + (PW + 1)'(r_pir);
        end
    end

    // final sum, round half up, saturate
    function automatic logic signed [AW-1:0] f_round_sat(input logic signed [SW-1:0] s);
        logic signed [SW-1:0] t;
        logic signed [QW-1:0] q;
        t = s + SW'(8192);
        q = $signed(t[SW-1:14]);
        if (q > Q_MAX) begin
            f_round_sat = Q_MAX[AW-1:0];
        end else if (q < Q_MIN) begin
            f_round_sat = Q_MIN[AW-1:0];
        end else begin
            f_round_sat = q[AW-1:0];
        end
    endfunction

    logic signed [SW-1:0] sum_re, sum_im;

    assign sum_re = SW'(r_s0_re) + SW'(r_prr) - SW'(r_pii);
    assign sum_im = SW'(r_s0_im) + SW'(r_pri) + SW'(r_pir);

    // output register
    logic                         r_out_valid;
    logic [MAX_QUBITS-1:0]        r_out_index;
    logic signed [AW-1:0]         r_real_out, r_imag_out;
    logic [sqg_pkg::STATUS_W-1:0] r_out_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_index  <= r_idx;
            r_out_status <= r_status;
            if (r_status == sqg_pkg::STATUS_OK) begin
                r_real_out <= f_round_sat(sum_re);
                r_imag_out <= f_round_sat(sum_im);
            end else begin
                r_real_out <= '0;
                r_imag_out <= '0;
            end
        end
    end

    assign o_sts.is_read  = (i_func == sqg_pkg::FUNC_READ);
    assign o_sts.item_err = (item_status != sqg_pkg::STATUS_OK);
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_index = r_out_index;
    assign o_real_out  = r_real_out;
    assign o_imag_out  = r_imag_out;
    assign o_status    = r_out_status;

endmodule

// ===== tb/sv/single_qubit_gate_apply_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// single_qubit_gate_apply_checker
// Watches the register port and both streaming channels. Keeps its own copy of
// the gate, the qubit settings and the amplitude store, works out the evolved
// amplitude for every read transaction and compares each returned transaction
// field by field with the oldest one still waiting.
// ----------------------------------------------------------------------------
module single_qubit_gate_apply_checker (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     psel,
    input  logic                                     penable,
    input  logic                                     pwrite,
    input  logic [sqg_pkg::PADDR_W-1:0]              paddr,
    input  logic [sqg_pkg::PDATA_W-1:0]              pwdata,
    input  logic                                     pready,
    input  logic                                     i_in_valid,
    input  logic                                     i_in_stall,
    input  logic                                     i_func,
    input  logic [sqg_pkg::MAX_QUBITS_DEF-1:0]       i_amp_index,
    input  logic [sqg_pkg::AMP_W-1:0]                i_real_in,
    input  logic [sqg_pkg::AMP_W-1:0]                i_imag_in,
    input  logic                                     i_out_valid,
    input  logic                                     i_out_stall,
    input  logic [sqg_pkg::MAX_QUBITS_DEF-1:0]       i_out_index,
    input  logic [sqg_pkg::AMP_W-1:0]                i_real_out,
    input  logic [sqg_pkg::AMP_W-1:0]                i_imag_out,
    input  logic [sqg_pkg::STATUS_W-1:0]             i_status,
    output int                                       o_fail_count,
    output int                                       o_pending,
    output int                                       o_checked
);

    localparam int MAXQ  = sqg_pkg::MAX_QUBITS_DEF;
    localparam int DEPTH = 1 << MAXQ;

    typedef struct packed {
        logic [MAXQ-1:0]              index;
        logic [sqg_pkg::AMP_W-1:0]    re;
        logic [sqg_pkg::AMP_W-1:0]    im;
        logic [sqg_pkg::STATUS_W-1:0] status;
    } t_amp_result;

    logic [sqg_pkg::GATE_W-1:0] gate [2][2];
    logic [sqg_pkg::QC_W-1:0]   qcount;
    logic [sqg_pkg::QC_W-1:0]   target;
    logic [31:0]                amp_store [DEPTH];
    t_amp_result                evolved_amps [$];
    int                         fails;
    int                         checked;

    assign o_fail_count = fails;
    assign o_pending    = evolved_amps.size();
    assign o_checked    = checked;

    initial begin
        fails   = 0;
        checked = 0;
        foreach (amp_store[i]) amp_store[i] = '0;
    end

    function automatic int qubits_in_use();
        return (qcount > MAXQ) ? MAXQ : int'(qcount);
    endfunction

    function automatic longint sext16(logic [15:0] v);
        return longint'($signed(v));
    endfunction

    // half-up rounding of a Q4.28 sum to Q2.14, then saturation
    function automatic logic [15:0] round_q14(longint acc);
        longint q;
        q = (acc + 64'sd8192) >>> 14;
        if (q > 32767) q = 32767;
        else if (q < -32768) q = -32768;
        return q[15:0];
    endfunction

    function automatic t_amp_result apply_gate(logic [MAXQ-1:0] idx);
        t_amp_result     r;
        int              n;
        logic [MAXQ-1:0] mask;
        logic            row;
        logic [31:0]     a0, a1, g0, g1;
        longint          ar0, ai0, ar1, ai1, gr0, gi0, gr1, gi1;
        n        = qubits_in_use();
        r.index  = idx;
        r.re     = '0;
        r.im     = '0;
        r.status = sqg_pkg::STATUS_OK;
        if (int'(idx) >= (1 << n)) begin
            r.status = sqg_pkg::STATUS_BAD_INDEX;
        end else if (target == 0 || int'(target) > n) begin
            r.status = sqg_pkg::STATUS_BAD_TARGET;
        end else begin
            mask = '0;
            mask[n - int'(target)] = 1'b1;
            row = |(idx & mask);
            a0  = amp_store[idx & ~mask];
            a1  = amp_store[idx | mask];
            g0  = gate[row][0];
            g1  = gate[row][1];
            ar0 = sext16(a0[31:16]);
            ai0 = sext16(a0[15:0]);
            ar1 = sext16(a1[31:16]);
            ai1 = sext16(a1[15:0]);
            gr0 = sext16(g0[31:16]);
            gi0 = sext16(g0[15:0]);
            gr1 = sext16(g1[31:16]);
            gi1 = sext16(g1[15:0]);
            r.re = round_q14(gr0 * ar0 - gi0 * ai0 + gr1 * ar1 - gi1 * ai1);
            r.im = round_q14(gr0 * ai0 + gi0 * ar0 + gr1 * ai1 + gi1 * ar1);
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_amp_result want;
        t_amp_result got;
        if (!i_rst_n) begin
            gate[0][0] = sqg_pkg::GATE_ONE;
            gate[0][1] = sqg_pkg::GATE_ZERO;
            gate[1][0] = sqg_pkg::GATE_ZERO;
            gate[1][1] = sqg_pkg::GATE_ONE;
            qcount     = sqg_pkg::QCOUNT_RST;
            target     = sqg_pkg::TARGET_RST;
            evolved_amps.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[sqg_pkg::PADDR_W-1:2])
                    sqg_pkg::REG_G00:    gate[0][0] = pwdata;
                    sqg_pkg::REG_G01:    gate[0][1] = pwdata;
                    sqg_pkg::REG_G10:    gate[1][0] = pwdata;
                    sqg_pkg::REG_G11:    gate[1][1] = pwdata;
                    sqg_pkg::REG_QCOUNT: qcount = pwdata[sqg_pkg::QC_W-1:0];
                    sqg_pkg::REG_TARGET: target = pwdata[sqg_pkg::QC_W-1:0];
                    default:    ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                got = '{i_out_index, i_real_out, i_imag_out, i_status};
                if (evolved_amps.size() == 0) begin
                    if (fails < 10)
                        $display("unexpected transaction: index %0d re %h im %h status %0d",
                                 got.index, got.re, got.im, got.status);
                    fails++;
                end else begin
                    want = evolved_amps.pop_front();
                    checked++;
                    if (got != want) begin
                        if (fails < 10)
                            $display({"mismatch: expected index %0d re %h im %h status %0d,",
                                      " got index %0d re %h im %h status %0d"},
                                     want.index, want.re, want.im, want.status,
                                     got.index, got.re, got.im, got.status);
                        fails++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_func == sqg_pkg::FUNC_READ)
                    evolved_amps.push_back(apply_gate(i_amp_index));
                else if (int'(i_amp_index) < (1 << qubits_in_use()))
                    amp_store[i_amp_index] = {i_real_in, i_imag_in};
            end
        end
    end

endmodule

// ===== tb/sv/single_qubit_gate_apply_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// single_qubit_gate_apply_tb
// Drives amplitude writes and gate reads into the block under a range of gate,
// qubit count and target settings, with random gaps on the sender and random
// stalls on the receiver. Valid reads are issued only after both partner
// amplitudes were written. Checking is done by the checker module beside the block.
// ----------------------------------------------------------------------------
module single_qubit_gate_apply_tb;

    localparam int          MAXQ          = sqg_pkg::MAX_QUBITS_DEF;
    localparam int          DEPTH         = 1 << MAXQ;
    localparam int          QUIET_LIMIT   = 2000;
    localparam int          PHASE_ITEMS   = 160;
    localparam logic [15:0] INV_SQRT2     = 16'h2D41;
    localparam logic [15:0] NEG_INV_SQRT2 = 16'hD2BF;

    logic                               i_clk;
    logic                               i_rst_n     = 1'b0;
    logic                               psel        = 1'b0;
    logic                               penable     = 1'b0;
    logic                               pwrite      = 1'b0;
    logic [sqg_pkg::PADDR_W-1:0]        paddr       = '0;
    logic [sqg_pkg::PDATA_W-1:0]        pwdata      = '0;
    logic [sqg_pkg::PDATA_W-1:0]        prdata;
    logic                               pready;
    logic                               i_in_valid  = 1'b0;
    logic                               o_in_stall;
    logic                               i_func      = sqg_pkg::FUNC_WRITE;
    logic [MAXQ-1:0]                    i_amp_index = '0;
    logic signed [sqg_pkg::AMP_W-1:0]   i_real_in   = '0;
    logic signed [sqg_pkg::AMP_W-1:0]   i_imag_in   = '0;
    logic                               o_out_valid;
    logic                               i_out_stall = 1'b0;
    logic [MAXQ-1:0]                    o_out_index;
    logic signed [sqg_pkg::AMP_W-1:0]   o_real_out;
    logic signed [sqg_pkg::AMP_W-1:0]   o_imag_out;
    logic [sqg_pkg::STATUS_W-1:0]       o_status;

    int          fail_count;
    int          pending;
    int          checked;
    int          src_idle_pct  = 0;
    int          snk_stall_pct = 0;
    logic [3:0]  cur_qc        = sqg_pkg::QCOUNT_RST;
    logic [3:0]  cur_tq        = sqg_pkg::TARGET_RST;
    bit          written [DEPTH];
    int          items_sent    = 0;
    int          reads_sent    = 0;
    int          settings_used = 1;
    int          quiet_cycles  = 0;
    int          qc_plan [8]   = '{10, 1, 4, 10, 7, 15, 2, 9};

    single_qubit_gate_apply DUT (.*);

    single_qubit_gate_apply_checker amp_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_func       (i_func),
        .i_amp_index  (i_amp_index),
        .i_real_in    (i_real_in),
        .i_imag_in    (i_imag_in),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_index  (o_out_index),
        .i_real_out   (o_real_out),
        .i_imag_out   (o_imag_out),
        .i_status     (o_status),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < snk_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || (psel && penable)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic int eff_n();
        return (cur_qc > MAXQ) ? MAXQ : int'(cur_qc);
    endfunction

    function automatic logic [15:0] rand_amp();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            4, 5: return 16'($urandom_range(0, 32768) - 16384);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] rand_gate();
        case ($urandom_range(0, 11))
            0: return sqg_pkg::GATE_ONE;
            1: return sqg_pkg::GATE_ZERO;
            2: return {INV_SQRT2, 16'h0000};
            3: return {NEG_INV_SQRT2, 16'h0000};
            4: return 32'h8000_8000;
            5: return 32'h7FFF_7FFF;
            6: return 32'h0000_4000;
            default: return $urandom;
        endcase
    endfunction

    task automatic apb_write(input logic [2:0] reg_idx, input logic [31:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_idx == sqg_pkg::REG_QCOUNT) cur_qc = value[3:0];
        if (reg_idx == sqg_pkg::REG_TARGET) cur_tq = value[3:0];
        @(posedge i_clk);
    endtask

    // hold off the sender until every read has come back and the block is quiet
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic configure(input logic [31:0] g00, input logic [31:0] g01,
                             input logic [31:0] g10, input logic [31:0] g11,
                             input logic [3:0] qc, input logic [3:0] tq);
        wait_drained();
        apb_write(sqg_pkg::REG_G00, g00);
        apb_write(sqg_pkg::REG_G01, g01);
        apb_write(sqg_pkg::REG_G10, g10);
        apb_write(sqg_pkg::REG_G11, g11);
        apb_write(sqg_pkg::REG_QCOUNT, {28'd0, qc});
        apb_write(sqg_pkg::REG_TARGET, {28'd0, tq});
        settings_used++;
    endtask

    task automatic send_item(input logic func, input logic [MAXQ-1:0] idx,
                             input logic [15:0] re, input logic [15:0] im);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_func      <= func;
        i_amp_index <= idx;
        i_real_in   <= re;
        i_imag_in   <= im;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
        if (func == sqg_pkg::FUNC_READ) reads_sent++;
        else if (int'(idx) < (1 << eff_n())) written[idx] = 1'b1;
    endtask

    // fills in any unwritten partner amplitude before the read
    task automatic send_read(input logic [MAXQ-1:0] idx);
        int              n;
        logic [MAXQ-1:0] mask;
        n = eff_n();
        if (int'(idx) < (1 << n) && cur_tq != 0 && int'(cur_tq) <= n) begin
            mask = '0;
            mask[n - int'(cur_tq)] = 1'b1;
            if (!written[idx & ~mask])
                send_item(sqg_pkg::FUNC_WRITE, idx & ~mask, rand_amp(), rand_amp());
            if (!written[idx | mask])
                send_item(sqg_pkg::FUNC_WRITE, idx | mask, rand_amp(), rand_amp());
        end
        send_item(sqg_pkg::FUNC_READ, idx, 16'($urandom), 16'($urandom));
    endtask

    initial begin : stimulus
        int         start;
        int         roll;
        int         n;
        logic [3:0] qc;
        logic [3:0] tq;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // full-scale amplitudes through the reset identity gate
        send_item(sqg_pkg::FUNC_WRITE, 10'd0, 16'h7FFF, 16'h8000);
        send_item(sqg_pkg::FUNC_WRITE, 10'd512, 16'h8000, 16'h7FFF);
        send_read(10'd0);
        send_read(10'd512);
        send_item(sqg_pkg::FUNC_WRITE, 10'd1023, 16'h4000, 16'hC000);
        send_item(sqg_pkg::FUNC_WRITE, 10'd511, INV_SQRT2, NEG_INV_SQRT2);
        send_read(10'd1023);
        send_read(10'd511);

        // hadamard on the top qubit
        configure({INV_SQRT2, 16'h0000}, {INV_SQRT2, 16'h0000},
                  {INV_SQRT2, 16'h0000}, {NEG_INV_SQRT2, 16'h0000}, 4'd10, 4'd1);
        send_read(10'd0);
        send_read(10'd512);
        send_read(10'd1023);

        // most negative complex entries drive the sums into saturation
        configure(32'h8000_8000, 32'h8000_8000, 32'h8000_8000, 32'h8000_8000, 4'd10, 4'd1);
        send_read(10'd0);
        send_read(10'd511);

        // zero qubits: only index 0 exists and no target fits
        configure(sqg_pkg::GATE_ONE, sqg_pkg::GATE_ZERO, sqg_pkg::GATE_ZERO,
                  sqg_pkg::GATE_ONE, 4'd0, 4'd1);
        send_item(sqg_pkg::FUNC_WRITE, 10'd1, 16'h1111, 16'h2222);
        send_read(10'd1);
        send_read(10'd0);
        send_item(sqg_pkg::FUNC_WRITE, 10'd0, 16'h1234, 16'hEDCB);

        // count above the maximum clamps, target zero is out of range
        configure(sqg_pkg::GATE_ONE, sqg_pkg::GATE_ZERO, sqg_pkg::GATE_ZERO,
                  sqg_pkg::GATE_ONE, 4'd15, 4'd0);
        send_read(10'd5);

        // least significant qubit as target
        configure(32'h0000_4000, sqg_pkg::GATE_ONE, 32'hC000_0000, 32'h0000_C000,
                  4'd15, 4'd10);
        send_item(sqg_pkg::FUNC_WRITE, 10'd2, 16'h7FFF, 16'h0001);
        send_item(sqg_pkg::FUNC_WRITE, 10'd3, 16'hFFFF, 16'h8000);
        send_read(10'd2);
        send_read(10'd3);

        // target beyond a small count, index beyond the state
        configure(sqg_pkg::GATE_ONE, sqg_pkg::GATE_ZERO, sqg_pkg::GATE_ZERO,
                  sqg_pkg::GATE_ONE, 4'd3, 4'd4);
        send_read(10'd6);
        send_read(10'd9);
        send_item(sqg_pkg::FUNC_WRITE, 10'd1023, 16'h7FFF, 16'h7FFF);

        for (int p = 0; p < 8; p++) begin
            qc = 4'(qc_plan[p]);
            n  = (qc > MAXQ) ? MAXQ : int'(qc);
            if (p == 0) tq = 4'd1;
            else if (p % 3 == 0) tq = 4'(n);
            else tq = 4'($urandom_range(1, n));
            configure(rand_gate(), rand_gate(), rand_gate(), rand_gate(), qc, tq);
            case (p % 4)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 74; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 74; end
                default: begin src_idle_pct = 15; snk_stall_pct = 15; end
            endcase
            start = items_sent;
            while (items_sent - start < PHASE_ITEMS) begin
                roll = $urandom_range(0, 99);
                if (roll < 2) begin
                    wait_drained();
                end else if (roll < 12 && n < MAXQ) begin
                    send_item(1'($urandom), 10'($urandom_range(1 << n, DEPTH - 1)),
                              16'($urandom), 16'($urandom));
                end else if (roll < 45) begin
                    send_item(sqg_pkg::FUNC_WRITE, 10'($urandom_range(0, (1 << n) - 1)),
                              rand_amp(), rand_amp());
                end else begin
                    send_read(10'($urandom_range(0, (1 << n) - 1)));
                end
            end
        end

        wait_drained();
        $display("sent %0d transactions (%0d reads) over %0d register settings",
                 items_sent, reads_sent, settings_used);
        $display("checked %0d evolved amplitudes, %0d failures", checked, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
